// ===== rtl/core/tbec_pkg.sv =====
// Shared constants and types for the touch button event classifier.
// No dependencies; used by every module under rtl/core.
package tbec_pkg;

  // Fixed field widths of the ports
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 16;
  localparam int IDX_W    = 2;
  localparam int KIND_W   = 2;

  // Defaults and fixed sizes
  localparam int              BUTTON_COUNT_DEF = 3;
  localparam logic [THR_W-1:0] THR_RESET       = 16'd1000;
  localparam int              QUEUE_DEPTH      = 2;

  // Event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SHORT   = 2'd2,
    KIND_LONG    = 2'd3
  } kind_t;

endpackage

// ===== rtl/core/touch_button_event_classifier_core.sv =====
// Top level of the touch button event classifier: front, record queue, back.
// Depends on tbec_pkg, tbec_front, tbec_queue and tbec_back.
//
//   channel  ports                                        handshake
//   in       in_touch_status, in_now_ms                   in_valid / in_stall
//   out      out_button_index, out_event_kind,            out_valid / out_stall
//            out_duration_ms, out_last_of_run
//   cfg      cfg_wr_data (threshold, ms)                  cfg_wr_en
//
// A sample is taken while the two-entry record queue has room;
// a sample that causes no event is dropped right there.
// The back sends one event per cycle while out_stall is low; a sample can
// carry up to 2 * BUTTON_COUNT events, and its first event passes the queue,
// the current-record register and the output register.
// Reset clears button state, queue and output; the threshold returns to 1000.
// out_stall holds the output register; the queue then fills and raises in_stall.
module touch_button_event_classifier_core #(
  parameter int BUTTON_COUNT = tbec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tbec_pkg::THR_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tbec_pkg::STATUS_W-1:0]   in_touch_status,
  input  logic [tbec_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tbec_pkg::IDX_W-1:0]      out_button_index,
  output logic [tbec_pkg::KIND_W-1:0]     out_event_kind,
  output logic [tbec_pkg::TIME_W-1:0]     out_duration_ms,
  output logic                            out_last_of_run
);

  logic                                          q_full, q_not_empty, q_push, q_pop;
  logic [2*BUTTON_COUNT-1:0]                     wr_vld, rd_vld;
  tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          wr_kind, rd_kind;
  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] wr_dur, rd_dur;

  tbec_front #(.BUTTON_COUNT(BUTTON_COUNT)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_touch_status (in_touch_status),
    .in_now_ms       (in_now_ms),
    .q_full          (q_full),
    .q_push          (q_push),
    .rec_vld         (wr_vld),
    .rec_kind        (wr_kind),
    .rec_dur         (wr_dur)
  );

  tbec_queue #(.BUTTON_COUNT(BUTTON_COUNT)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_vld    (wr_vld),
    .wr_kind   (wr_kind),
    .wr_dur    (wr_dur),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rd_vld    (rd_vld),
    .rd_kind   (rd_kind),
    .rd_dur    (rd_dur)
  );

  tbec_back #(.BUTTON_COUNT(BUTTON_COUNT)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_pop            (q_pop),
    .head_vld         (rd_vld),
    .head_kind        (rd_kind),
    .head_dur         (rd_dur),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_button_index (out_button_index),
    .out_event_kind   (out_event_kind),
    .out_duration_ms  (out_duration_ms),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== rtl/core/tbec_front.sv =====
// Front part: accepts status samples, keeps per-button state, builds the
// event record of each sample. Depends on tbec_pkg.
module tbec_front #(
  parameter int BUTTON_COUNT = tbec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wr_en,
  input  logic [tbec_pkg::THR_W-1:0]                    cfg_wr_data,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [tbec_pkg::STATUS_W-1:0]                 in_touch_status,
  input  logic [tbec_pkg::TIME_W-1:0]                   in_now_ms,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [2*BUTTON_COUNT-1:0]                     rec_vld,
  output tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          rec_kind,
  output logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] rec_dur
);

  localparam int SW = (BUTTON_COUNT > tbec_pkg::STATUS_W) ? BUTTON_COUNT
                                                          : tbec_pkg::STATUS_W;

  logic [tbec_pkg::THR_W-1:0]                    thr_r, thr_nxt;
  logic [BUTTON_COUNT-1:0]                       prev_r, prev_nxt;
  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] start_r, start_nxt;
  logic [BUTTON_COUNT-1:0]                       long_r, long_nxt;

  logic [SW-1:0]                                 st_ext;
  logic [BUTTON_COUNT-1:0]                       st;
  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] held_dur;
  logic [BUTTON_COUNT-1:0]                       reach;
  logic                                          accept;

  // Status bits beyond the button count are dropped
  assign st_ext   = SW'(in_touch_status);
  assign st       = st_ext[BUTTON_COUNT-1:0];
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify each button in its own lane
  always_comb begin
    rec_vld   = '0;
    rec_kind  = {(2*BUTTON_COUNT){tbec_pkg::KIND_PRESS}};
    rec_dur   = '0;
    start_nxt = start_r;
    long_nxt  = long_r;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      held_dur[i] = in_now_ms - start_r[i];
      reach[i]    = held_dur[i] >= {{(tbec_pkg::TIME_W-tbec_pkg::THR_W){1'b0}}, thr_r};
      if (st[i] && !prev_r[i]) begin
        rec_vld[2*i]  = 1'b1;
        rec_kind[2*i] = tbec_pkg::KIND_PRESS;
        start_nxt[i]  = in_now_ms;
        long_nxt[i]   = 1'b0;
      end else if (!st[i] && prev_r[i]) begin
        rec_vld[2*i]    = 1'b1;
        rec_kind[2*i]   = tbec_pkg::KIND_RELEASE;
        rec_vld[2*i+1]  = !long_r[i];
        rec_kind[2*i+1] = reach[i] ? tbec_pkg::KIND_LONG : tbec_pkg::KIND_SHORT;
        rec_dur[i]      = held_dur[i];
        start_nxt[i]    = '0;
        long_nxt[i]     = 1'b0;
      end else if (st[i] && prev_r[i] && !long_r[i] && reach[i]) begin
        rec_vld[2*i]  = 1'b1;
        rec_kind[2*i] = tbec_pkg::KIND_LONG;
        rec_dur[i]    = held_dur[i];
        long_nxt[i]   = 1'b1;
      end
    end
  end

  // Push only samples that cause at least one event
  assign q_push   = accept && (|rec_vld);
  assign prev_nxt = st;
  assign thr_nxt  = cfg_wr_en ? cfg_wr_data : thr_r;

  // Advance button state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= tbec_pkg::THR_RESET;
      prev_r  <= '0;
      start_r <= '0;
      long_r  <= '0;
    end else begin
      thr_r <= thr_nxt;
      if (accept) begin
        prev_r  <= prev_nxt;
        start_r <= start_nxt;
        long_r  <= long_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/tbec_queue.sv =====
// Short record queue between the front and back parts.
// Depends on tbec_pkg.
module tbec_queue #(
  parameter int BUTTON_COUNT = tbec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  input  logic [2*BUTTON_COUNT-1:0]                     wr_vld,
  input  tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          wr_kind,
  input  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] wr_dur,
  output logic                                          full,
  output logic                                          not_empty,
  input  logic                                          pop,
  output logic [2*BUTTON_COUNT-1:0]                     rd_vld,
  output tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          rd_kind,
  output logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] rd_dur
);

  localparam int DEPTH = tbec_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [2*BUTTON_COUNT-1:0]                     vld_q  [DEPTH];
  tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          kind_q [DEPTH];
  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] dur_q  [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  assign rd_vld  = vld_q[rd_ptr_r];
  assign rd_kind = kind_q[rd_ptr_r];
  assign rd_dur  = dur_q[rd_ptr_r];

  // Pointer and fill level updates
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk) begin
    if (do_push) begin
      vld_q[wr_ptr_r]  <= wr_vld;
      kind_q[wr_ptr_r] <= wr_kind;
      dur_q[wr_ptr_r]  <= wr_dur;
    end
  end

endmodule

// ===== rtl/core/tbec_back.sv =====
// Back part: walks the current record and sends one event per transfer
// through a registered output. Depends on tbec_pkg.
module tbec_back #(
  parameter int BUTTON_COUNT = tbec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_not_empty,
  output logic                                          q_pop,
  input  logic [2*BUTTON_COUNT-1:0]                     head_vld,
  input  tbec_pkg::kind_t [2*BUTTON_COUNT-1:0]          head_kind,
  input  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] head_dur,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [tbec_pkg::IDX_W-1:0]                    out_button_index,
  output logic [tbec_pkg::KIND_W-1:0]                   out_event_kind,
  output logic [tbec_pkg::TIME_W-1:0]                   out_duration_ms,
  output logic                                          out_last_of_run
);

  localparam int NSLOT = 2 * BUTTON_COUNT;

  logic [NSLOT-1:0]                              cur_vld_r, cur_vld_nxt;
  tbec_pkg::kind_t [NSLOT-1:0]                   cur_kind_r;
  logic [BUTTON_COUNT-1:0][tbec_pkg::TIME_W-1:0] cur_dur_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [tbec_pkg::IDX_W-1:0]    out_idx_r;
  tbec_pkg::kind_t               out_kind_r;
  logic [tbec_pkg::TIME_W-1:0]   out_dur_r;
  logic                          out_last_r;

  logic [NSLOT-1:0]              hit;
  logic [NSLOT-1:0]              rest;
  logic [tbec_pkg::IDX_W-1:0]    sel_idx;
  tbec_pkg::kind_t               sel_kind;
  logic [tbec_pkg::TIME_W-1:0]   sel_dur;
  logic                          out_free, emit;

  // Pick the lowest pending slot
  always_comb begin
    hit      = '0;
    sel_idx  = '0;
    sel_kind = tbec_pkg::KIND_PRESS;
    sel_dur  = '0;
    for (int j = NSLOT - 1; j >= 0; j--) begin
      if (cur_vld_r[j]) begin
        hit      = '0;
        hit[j]   = 1'b1;
        sel_idx  = tbec_pkg::IDX_W'(j >> 1);
        sel_kind = cur_kind_r[j];
        sel_dur  = cur_dur_r[j >> 1];
      end
    end
  end

  assign rest     = cur_vld_r & ~hit;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = out_free && (|cur_vld_r);

  // Load the next record once the current one is used up
  always_comb begin
    cur_vld_nxt = emit ? rest : cur_vld_r;
    q_pop       = q_not_empty && (cur_vld_nxt == '0);
    if (q_pop) begin
      cur_vld_nxt = head_vld;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_vld_r   <= cur_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_kind_r <= head_kind;
      cur_dur_r  <= head_dur;
    end
    if (emit) begin
      out_idx_r  <= sel_idx;
      out_kind_r <= sel_kind;
      out_dur_r  <= (sel_kind == tbec_pkg::KIND_PRESS) ? '0 : sel_dur;
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_index = out_idx_r;
  assign out_event_kind   = out_kind_r;
  assign out_duration_ms  = out_dur_r;
  assign out_last_of_run  = out_last_r;

endmodule
